>>> hw/rtl/assert_macros.svh
// Assertion helpers, clocked on the rising edge, disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// label: prop holds at every edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// label: ante at one edge implies cons at the next edge
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/sts_pkg.sv
package sts_pkg;

    localparam int CAPACITY  = 64;
    localparam int KEY_WIDTH = 32;
    localparam int IDX_W     = 6;
    localparam int CNT_W     = 7;

    localparam logic [1:0] CMD_SEARCH = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_RANGE = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]           cmd;
        logic [KEY_WIDTH-1:0] key;
        logic                 whole_table;
        logic [IDX_W-1:0]     range_low;
        logic [IDX_W-1:0]     range_high;
    } req_t;

    typedef struct packed {
        logic             found;
        logic [CNT_W-1:0] position;
        logic [CNT_W-1:0] entry_count;
        logic [1:0]       status;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_CMP,
        ST_WALK,
        ST_WALK_CMP,
        ST_ACT,
        ST_SHIFT
    } state_t;

endpackage

>>> hw/rtl/sorted_table_search_insert_remove.sv
// Flow: an empty-table or range-error item is answered straight from idle;
//   otherwise each binary search step and each entry walked back is a read
//   then a compare, and an insert or remove shifts the moved entries (one
//   memory port); worst case walks back 63 equal entries, then shifts 63.
// Throughput: one item at a time; busy, if raised, holds until its result strobe.
// Reset: count and sort order cleared, no clearing pass; results never stall.
module sorted_table_search_insert_remove
    import sts_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t req,
    output logic done,
    output rsp_t rsp,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic cfg_data
);

    logic [KEY_WIDTH-1:0] mem [CAPACITY];

    state_t               state_reg, state_next;
    logic [1:0]           cmd_reg, cmd_next;
    logic [KEY_WIDTH-1:0] key_reg, key_next;
    logic [CNT_W-1:0]     lo_reg, lo_next;
    logic [CNT_W-1:0]     hp_reg, hp_next;
    logic [IDX_W-1:0]     mid_reg, mid_next;
    logic [CNT_W-1:0]     pos_reg, pos_next;
    logic                 found_reg, found_next;
    logic [IDX_W-1:0]     src_reg, src_next;
    logic [IDX_W-1:0]     wsrc_reg, wsrc_next;
    logic [CNT_W-1:0]     rem_reg, rem_next;
    logic                 pend_reg, pend_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 desc_reg;
    logic                 done_reg, done_next;
    rsp_t                 rsp_reg, rsp_next;
    logic [KEY_WIDTH-1:0] rd_data_reg;

    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    logic [KEY_WIDTH-1:0] mem_wdata;
    logic [IDX_W-1:0]     rd_addr;
    logic [CNT_W:0]       mid_sum;
    logic                 range_bad;
    logic                 is_ins;

    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign rsp       = rsp_reg;
    assign cfg_ready = ~busy;
    assign is_ins    = (cmd_reg == CMD_INSERT);
    assign mid_sum   = {1'b0, lo_reg} + {1'b0, hp_reg} - (CNT_W+1)'(1);

    always_comb
    begin
        if (req.whole_table)
        begin
            range_bad = (count_reg == '0);
        end
        else
        begin
            range_bad = ({1'b0, req.range_low} >= count_reg)
                     || ({1'b0, req.range_high} >= count_reg)
                     || (req.range_low > req.range_high);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        key_next   = key_reg;
        lo_next    = lo_reg;
        hp_next    = hp_reg;
        mid_next   = mid_reg;
        pos_next   = pos_reg;
        found_next = found_reg;
        src_next   = src_reg;
        wsrc_next  = wsrc_reg;
        rem_next   = rem_reg;
        pend_next  = pend_reg;
        count_next = count_reg;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;
        mem_we     = 1'b0;
        mem_waddr  = '0;
        mem_wdata  = key_reg;
        rd_addr    = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if ((count_reg == '0) && req.whole_table && (req.cmd != CMD_REMOVE))
                    begin
                        if (req.cmd == CMD_INSERT)
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = '0;
                            mem_wdata  = req.key;
                            count_next = CNT_W'(1);
                        end
                        rsp_next.found       = 1'b0;
                        rsp_next.position    = '0;
                        rsp_next.entry_count = count_next;
                        rsp_next.status      = STATUS_OK;
                        done_next            = 1'b1;
                    end
                    else if (range_bad)
                    begin
                        rsp_next.found       = 1'b0;
                        rsp_next.position    = '0;
                        rsp_next.entry_count = count_reg;
                        rsp_next.status      = STATUS_RANGE;
                        done_next            = 1'b1;
                    end
                    else
                    begin
                        cmd_next   = req.cmd;
                        key_next   = req.key;
                        found_next = 1'b0;
                        pend_next  = 1'b0;
                        if (req.whole_table)
                        begin
                            lo_next = '0;
                            hp_next = count_reg;
                        end
                        else
                        begin
                            lo_next = {1'b0, req.range_low};
                            hp_next = {1'b0, req.range_high} + CNT_W'(1);
                        end
                        state_next = ST_SEARCH;
                    end
                end
            end

            ST_SEARCH:
            begin
                if (lo_reg < hp_reg)
                begin
                    rd_addr    = mid_sum[IDX_W:1];
                    mid_next   = mid_sum[IDX_W:1];
                    state_next = ST_CMP;
                end
                else
                begin
                    pos_next   = hp_reg;
                    found_next = 1'b0;
                    state_next = ST_ACT;
                end
            end

            ST_CMP:
            begin
                if (rd_data_reg == key_reg)
                begin
                    pos_next   = {1'b0, mid_reg};
                    found_next = 1'b1;
                    state_next = ST_WALK;
                end
                else
                begin
                    if (desc_reg ? (key_reg > rd_data_reg) : (key_reg < rd_data_reg))
                    begin
                        hp_next = {1'b0, mid_reg};
                    end
                    else
                    begin
                        lo_next = {1'b0, mid_reg} + CNT_W'(1);
                    end
                    state_next = ST_SEARCH;
                end
            end

            ST_WALK:
            begin
                if (pos_reg == '0)
                begin
                    state_next = ST_ACT;
                end
                else
                begin
                    rd_addr    = IDX_W'(pos_reg - CNT_W'(1));
                    state_next = ST_WALK_CMP;
                end
            end

            ST_WALK_CMP:
            begin
                if (rd_data_reg == key_reg)
                begin
                    pos_next   = pos_reg - CNT_W'(1);
                    state_next = ST_WALK;
                end
                else
                begin
                    state_next = ST_ACT;
                end
            end

            ST_ACT:
            begin
                if (is_ins && (count_reg < CNT_W'(CAPACITY)))
                begin
                    rem_next   = count_reg - pos_reg;
                    src_next   = IDX_W'(count_reg - CNT_W'(1));
                    pend_next  = 1'b0;
                    state_next = ST_SHIFT;
                end
                else if ((cmd_reg == CMD_REMOVE) && found_reg)
                begin
                    rem_next   = count_reg - pos_reg - CNT_W'(1);
                    src_next   = IDX_W'(pos_reg + CNT_W'(1));
                    pend_next  = 1'b0;
                    state_next = ST_SHIFT;
                end
                else
                begin
                    rsp_next.found       = found_reg;
                    rsp_next.position    = pos_reg;
                    rsp_next.entry_count = count_reg;
                    rsp_next.status      = is_ins ? STATUS_FULL : STATUS_OK;
                    done_next            = 1'b1;
                    state_next           = ST_IDLE;
                end
            end

            ST_SHIFT:
            begin
                // read one source per cycle, write it one slot over the next
                if (rem_reg != '0)
                begin
                    rd_addr   = src_reg;
                    wsrc_next = src_reg;
                    pend_next = 1'b1;
                    rem_next  = rem_reg - CNT_W'(1);
                    src_next  = is_ins ? (src_reg - IDX_W'(1)) : (src_reg + IDX_W'(1));
                end
                else
                begin
                    pend_next = 1'b0;
                end

                if (pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = is_ins ? (wsrc_reg + IDX_W'(1)) : (wsrc_reg - IDX_W'(1));
                    mem_wdata = rd_data_reg;
                end
                else if (rem_reg == '0)
                begin
                    if (is_ins)
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = pos_reg[IDX_W-1:0];
                        mem_wdata  = key_reg;
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        count_next = count_reg - CNT_W'(1);
                    end
                    rsp_next.found       = found_reg;
                    rsp_next.position    = pos_reg;
                    rsp_next.entry_count = count_next;
                    rsp_next.status      = STATUS_OK;
                    done_next            = 1'b1;
                    state_next           = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            desc_reg  <= 1'b0;
            done_reg  <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
            pend_reg  <= pend_next;
            if (cfg_valid && cfg_ready)
            begin
                desc_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        key_reg   <= key_next;
        lo_reg    <= lo_next;
        hp_reg    <= hp_next;
        mid_reg   <= mid_next;
        pos_reg   <= pos_next;
        found_reg <= found_next;
        src_reg   <= src_next;
        wsrc_reg  <= wsrc_next;
        rem_reg   <= rem_next;
        rsp_reg   <= rsp_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

endmodule

>>> hw/rtl/sts_checker.sv
`include "assert_macros.svh"

module sts_checker
    import sts_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input rsp_t rsp
);

    `ASSERT_NEXT(a_item_progress, clk, rst_n, start && !busy, busy || done, "item lost")
    `ASSERT_CLK(a_count_bound, clk, rst_n, !done || (rsp.entry_count <= CNT_W'(CAPACITY)), "count")
    `ASSERT_CLK(a_range_clean, clk, rst_n, !(done && (rsp.status == STATUS_RANGE)) || (!rsp.found && (rsp.position == '0)), "range result")
    `ASSERT_CLK(a_full_count, clk, rst_n, !(done && (rsp.status == STATUS_FULL)) || (rsp.entry_count == CNT_W'(CAPACITY)), "full result")
    `ASSERT_CLK(a_status_code, clk, rst_n, !done || (rsp.status != 2'd3), "status code")

endmodule

bind sorted_table_search_insert_remove sts_checker u_sts_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
);

>>> test/tb_top.sv
`timescale 1ns / 1ps

module tb_top
    import sts_pkg::*;
();

    localparam logic [1:0] CMD_SPARE = 2'd3;
    localparam int         TAIL_CYCLES = 80;

    class table_scoreboard;
        logic [KEY_WIDTH-1:0] keys [CAPACITY];
        int   fill;
        bit   descending;
        rsp_t pending [$];
        int   errors;
        int   replies;
        int   full_hits;

        function new();
            foreach (keys[i])
                keys[i] = '0;
            fill = 0;
            descending = 0;
            errors = 0;
            replies = 0;
            full_hits = 0;
        endfunction

        function void set_order(bit desc);
            descending = desc;
        endfunction

        // binary search, then walk back over equal keys (may go below lo)
        function bit locate(logic [KEY_WIDTH-1:0] k, int lo, int hi, output int pos);
            int mid;
            while (lo <= hi)
            begin
                mid = (lo + hi) / 2;
                if (keys[mid] == k)
                begin
                    while (mid > 0 && keys[mid-1] == k)
                        mid--;
                    pos = mid;
                    return 1;
                end
                if (descending ? (k > keys[mid]) : (k < keys[mid]))
                    hi = mid - 1;
                else
                    lo = mid + 1;
            end
            pos = hi + 1;
            return 0;
        endfunction

        function void note_command(req_t r);
            rsp_t e;
            int   lo;
            int   hi;
            int   pos;
            int   i;
            bit   hit;
            e = '0;
            e.status = STATUS_OK;
            pos = 0;
            hit = 0;
            if (r.whole_table)
            begin
                lo = 0;
                hi = fill - 1;
            end
            else
            begin
                lo = r.range_low;
                hi = r.range_high;
            end
            if (fill == 0 && r.whole_table && r.cmd != CMD_REMOVE)
            begin
                if (r.cmd == CMD_INSERT)
                begin
                    keys[0] = r.key;
                    fill = 1;
                end
            end
            else if (lo >= fill || hi >= fill || lo > hi)
                e.status = STATUS_RANGE;
            else
            begin
                hit = locate(r.key, lo, hi, pos);
                if (r.cmd == CMD_INSERT)
                begin
                    if (fill >= CAPACITY)
                    begin
                        e.status = STATUS_FULL;
                        full_hits++;
                    end
                    else
                    begin
                        for (i = fill; i > pos; i--)
                            keys[i] = keys[i-1];
                        keys[pos] = r.key;
                        fill++;
                    end
                end
                else if (r.cmd == CMD_REMOVE && hit)
                begin
                    for (i = pos; i + 1 < fill; i++)
                        keys[i] = keys[i+1];
                    fill--;
                end
            end
            e.found = hit;
            e.position = pos[CNT_W-1:0];
            e.entry_count = fill[CNT_W-1:0];
            pending.push_back(e);
        endfunction

        task report_mismatch(string what);
            errors++;
            $display("[%0t] MISMATCH item %0d: %s", $realtime, replies, what);
        endtask

        task check_reply(rsp_t got);
            rsp_t e;
            if (pending.size() == 0)
            begin
                report_mismatch($sformatf("unexpected reply %p", got));
                return;
            end
            e = pending.pop_front();
            if (got.found !== e.found)
                report_mismatch($sformatf("found %0d, want %0d", got.found, e.found));
            if (got.position !== e.position)
                report_mismatch($sformatf("position %0d, want %0d", got.position, e.position));
            if (got.entry_count !== e.entry_count)
                report_mismatch($sformatf("entry_count %0d, want %0d",
                                          got.entry_count, e.entry_count));
            if (got.status !== e.status)
                report_mismatch($sformatf("status %0d, want %0d", got.status, e.status));
            replies++;
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    req_t req = '0;
    logic done;
    rsp_t rsp;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic cfg_data = 1'b0;

    table_scoreboard sb = new();
    bit steady = 0;

    sorted_table_search_insert_remove dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_reply(rsp);
    end

    function automatic bit idle_now();
        return !steady && $urandom_range(99) < 31;
    endfunction

    function automatic req_t make_req(logic [1:0] cmd, logic [KEY_WIDTH-1:0] key,
                                      int whole, int lo, int hi);
        req_t r;
        r.cmd = cmd;
        r.key = key;
        r.whole_table = (whole != 0);
        r.range_low = lo[IDX_W-1:0];
        r.range_high = hi[IDX_W-1:0];
        return r;
    endfunction

    function automatic logic [KEY_WIDTH-1:0] pick_key();
        int sel;
        sel = $urandom_range(99);
        if (sel < 40 && sb.fill > 0)
            return sb.keys[$urandom_range(sb.fill - 1)];
        if (sel < 70)
            return $urandom_range(15);
        if (sel < 80)
            return ($urandom_range(1) != 0) ? '1 : '0;
        return $urandom;
    endfunction

    function automatic req_t rand_command(int ins_pct, int rem_pct);
        req_t r;
        int   sel;
        int   lo;
        int   hi;
        sel = $urandom_range(99);
        if (sel < ins_pct)
            r.cmd = CMD_INSERT;
        else if (sel < ins_pct + rem_pct)
            r.cmd = CMD_REMOVE;
        else
            r.cmd = ($urandom_range(9) == 0) ? CMD_SPARE : CMD_SEARCH;
        r.key = pick_key();
        r.range_low = IDX_W'($urandom);
        r.range_high = IDX_W'($urandom);
        sel = $urandom_range(99);
        if (r.cmd == CMD_INSERT ? sel < 85 : sel < 60)
            r.whole_table = 1'b1;
        else
        begin
            r.whole_table = 1'b0;
            if (sel < 92 && sb.fill > 0)
            begin
                lo = $urandom_range(sb.fill - 1);
                hi = $urandom_range(sb.fill - 1, lo);
                r.range_low = lo[IDX_W-1:0];
                r.range_high = hi[IDX_W-1:0];
            end
        end
        return r;
    endfunction

    // start stays high after acceptance until the next item or stop_commands
    task automatic send_command(input req_t r);
        bit taken;
        taken = 0;
        req <= r;
        start <= !idle_now();
        while (!taken)
        begin
            @(posedge clk);
            if (start && !busy)
            begin
                taken = 1;
                sb.note_command(r);
            end
            else
                start <= !idle_now();
        end
    endtask

    task automatic stop_commands();
        start <= 1'b0;
    endtask

    task automatic quiesce();
        stop_commands();
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_sort_order(input bit desc);
        cfg_valid <= 1'b1;
        cfg_data <= desc;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_order(desc);
        cfg_valid <= 1'b0;
    endtask

    // removing index 0 over range 0..0 always hits, sorted or not
    task automatic drain_table();
        while (sb.fill > 0)
            send_command(make_req(CMD_REMOVE, sb.keys[0], 0, 0, 0));
    endtask

    task automatic fill_table();
        while (sb.fill < CAPACITY)
            send_command(make_req(CMD_INSERT, pick_key(), 1, $urandom, $urandom));
        repeat (3)
            send_command(make_req(CMD_INSERT, pick_key(), 1, 0, 0));
        send_command(make_req(CMD_INSERT, $urandom, 0, 10, 40));
    endtask

    bit order_plan [6] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};

    initial
    begin
        int ph;
        int n;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // empty table
        send_command(make_req(CMD_SEARCH, 32'd7, 1, 0, 0));
        send_command(make_req(CMD_SPARE, 32'd0, 1, 63, 63));
        send_command(make_req(CMD_REMOVE, 32'd7, 1, 0, 0));
        send_command(make_req(CMD_SEARCH, 32'd7, 0, 0, 0));
        send_command(make_req(CMD_INSERT, 32'd100, 1, 0, 0));
        send_command(make_req(CMD_INSERT, 32'd0, 1, 0, 0));
        send_command(make_req(CMD_INSERT, 32'hFFFF_FFFF, 1, 0, 0));
        send_command(make_req(CMD_INSERT, 32'd100, 1, 0, 0));
        send_command(make_req(CMD_INSERT, 32'd100, 1, 0, 0));
        // duplicates and walk back below range_low
        send_command(make_req(CMD_SEARCH, 32'd100, 1, 0, 0));
        send_command(make_req(CMD_SEARCH, 32'd100, 0, 3, 3));
        // bad ranges, then mixed commands on valid ranges
        send_command(make_req(CMD_SEARCH, 32'd100, 0, 2, 1));
        send_command(make_req(CMD_SEARCH, 32'd100, 0, 0, 5));
        send_command(make_req(CMD_REMOVE, 32'd100, 0, 63, 63));
        send_command(make_req(CMD_INSERT, 32'd100, 0, 5, 5));
        send_command(make_req(CMD_INSERT, 32'd50, 0, 1, 3));
        send_command(make_req(CMD_SEARCH, 32'd200, 1, 0, 0));
        send_command(make_req(CMD_SPARE, 32'd0, 1, 0, 0));
        send_command(make_req(CMD_REMOVE, 32'd100, 1, 0, 0));
        send_command(make_req(CMD_REMOVE, 32'd12345, 1, 0, 0));
        send_command(make_req(CMD_REMOVE, 32'hFFFF_FFFF, 0, 0, 0));
        send_command(make_req(CMD_SEARCH, 32'hFFFF_FFFF, 1, 0, 0));
        send_command(make_req(CMD_INSERT, 32'h8000_0000, 1, 0, 0));

        for (ph = 0; ph < 6; ph++)
        begin
            if (ph != 5)
                drain_table();
            quiesce();
            write_sort_order(order_plan[ph]);
            steady = (ph == 2);
            if (ph == 1 || ph == 3)
                fill_table();
            for (n = 0; n < 85; n++)
                send_command((ph % 2) ? rand_command(55, 20) : rand_command(35, 35));
        end

        stop_commands();
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d items in both sort orders, %0d inserts on a full table,",
                 sb.replies, sb.full_hits);
        $display("with idle gaps and one gap-free stretch; %0d mismatches", sb.errors);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("timeout");
        $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> sorted_table_search_insert_remove.f
+incdir+hw/rtl
hw/rtl/sts_pkg.sv
hw/rtl/sorted_table_search_insert_remove.sv
hw/rtl/sts_checker.sv
test/tb_top.sv
